// File: hw/rtl/tnns_pkg.sv
`timescale 1ns / 1ps
package tnns_pkg;
    localparam int TREE_DEPTH  = 2048;
    localparam int JOINT_COUNT = 6;
    localparam int ANGLE_WIDTH = 16;
    localparam int IDX_W   = $clog2(TREE_DEPTH);
    localparam int CNT_W   = $clog2(TREE_DEPTH + 1);
    localparam int DIFF_W  = ANGLE_WIDTH + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 3;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int STEP_W  = 15;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W  = STEP_W + DIFF_W + 1;
    localparam int QUO_W   = PROD_W;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef angle_t [JOINT_COUNT-1:0] node_t;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_STEP = 3'd0,
        CFG_J0   = 3'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]       command;
        node_t            angle;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] nearest_index;
        logic             found;
        node_t            steered;
        logic [CNT_W-1:0] stored_nodes;
        logic             dropped;
    } out_item_t;
endpackage

// File: hw/rtl/tnns_if.sv
`timescale 1ns / 1ps
interface tnns_in_if;
    import tnns_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tnns_out_if;
    import tnns_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tree_nearest_node_and_steer.sv
`timescale 1ns / 1ps
// Restart, append, unused command or query on an empty store: go to ST_OUT, which registers the result.
// Query on N nodes: ST_SCAN reads the node memory one node per cycle, then ST_FETCH, a
// 19-step root and six divisions sharing one restoring divider (root and divisions are
// skipped when the sample lies within one step).
// One item at a time; input is ready again the cycle after the result transfer.
// Reset: store empty, state and config registers at defaults; memory not cleared.
module tree_nearest_node_and_steer
(
    input  logic                           clk,
    input  logic                           rst_n,
    tnns_in_if.sink                        in_ch,
    tnns_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [tnns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tnns_pkg::CFG_W-1:0]     cfg_data
);
    import tnns_pkg::*;

    node_t mem [TREE_DEPTH];
    node_t rd_reg;

    logic [STEP_W-1:0]      step_reg;
    logic [CFG_W-1:0]       lim_reg [JOINT_COUNT];
    logic [CNT_W-1:0]       total_reg;
    state_t                 state_reg, state_next;
    in_item_t               item_reg;
    logic                   drop_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   cmp_v_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [SUM_W-1:0]       best_s_reg;
    node_t                  near_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [5:0]             it_reg;
    logic [2:0]             j_reg;
    logic [QUO_W-1:0]       dq_reg;
    logic [QUO_W:0]         dr_reg;
    logic                   dneg_reg;
    logic signed [ANGLE_WIDTH+1:0] res_reg [JOINT_COUNT];
    out_item_t              out_reg;
    logic                   out_v_reg;

    logic                   in_xfer;
    logic [SUM_W-1:0]       node_dist;
    logic                   scan_win;
    logic [IDX_W-1:0]       rd_addr;
    logic [SUM_W-1:0]       step_sq;

    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_v_reg;
    assign out_ch.valid = out_v_reg;
    assign out_ch.data  = out_reg;
    assign rd_addr      = cnt_reg[IDX_W-1:0];
    assign step_sq      = SUM_W'((2*STEP_W)'(step_reg) * (2*STEP_W)'(step_reg));
    assign scan_win     = cmp_v_reg && (cmp_idx_reg == '0 || node_dist < best_s_reg);

    always_comb
    begin
        logic signed [DIFF_W-1:0] d;
        logic signed [SQ_W-1:0]   dw;
        node_dist = '0;
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            d  = DIFF_W'(item_reg.angle[j]) - DIFF_W'(rd_reg[j]);
            dw = SQ_W'(d);
            node_dist = node_dist + SUM_W'(unsigned'(dw * dw));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && ((in_ch.data.command == CMD_RESTART) ||
            (in_ch.data.command == CMD_APPEND && total_reg != CNT_W'(TREE_DEPTH))))
        begin
            mem[(in_ch.data.command == CMD_RESTART) ? '0 : total_reg[IDX_W-1:0]]
                <= in_ch.data.angle;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_W'(205);
            lim_reg[0] <= 32'd834063946;
            lim_reg[1] <= 32'd609147826;
            lim_reg[2] <= 32'd632478286;
            lim_reg[3] <= 32'd834063946;
            lim_reg[4] <= 32'd599710786;
            lim_reg[5] <= 32'd1686608761;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_STEP)
                step_reg <= cfg_data[STEP_W-1:0];
            else if (cfg_index <= CFG_IDX_W'(JOINT_COUNT))
                lim_reg[cfg_index - CFG_J0] <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer)
                          state_next = (in_ch.data.command == CMD_QUERY && total_reg != '0)
                                       ? ST_SCAN : ST_OUT;
            ST_SCAN:  if (cnt_reg == total_reg) state_next = ST_FETCH;
            ST_FETCH: if (!cmp_v_reg && it_reg == 6'd1)
                          state_next = (best_s_reg > step_sq) ? ST_ROOT : ST_OUT;
            ST_ROOT:  if (it_reg == 6'(ROOT_W)) state_next = ST_DIV;
            ST_DIV:   if (it_reg == 6'(QUO_W) && j_reg == 3'(JOINT_COUNT - 1))
                          state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            out_v_reg <= 1'b0;
            cmp_v_reg <= 1'b0;
            cnt_reg   <= '0;
            it_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT) out_v_reg <= 1'b1;
            else if (out_ch.ready) out_v_reg <= 1'b0;
            if (in_xfer)
            begin
                cnt_reg   <= '0;
                it_reg    <= '0;
                cmp_v_reg <= 1'b0;
                if (in_ch.data.command == CMD_RESTART)
                    total_reg <= CNT_W'(1);
                else if (in_ch.data.command == CMD_APPEND &&
                         total_reg != CNT_W'(TREE_DEPTH))
                    total_reg <= total_reg + 1'b1;
            end
            unique case (state_reg)
                ST_SCAN:
                begin
                    cmp_v_reg   <= (cnt_reg != total_reg);
                    cmp_idx_reg <= rd_addr;
                    if (cnt_reg != total_reg) cnt_reg <= cnt_reg + 1'b1;
                    else cnt_reg <= CNT_W'(scan_win ? cmp_idx_reg : best_idx_reg);
                end
                ST_FETCH:
                begin
                    cmp_v_reg <= 1'b0;
                    cnt_reg   <= CNT_W'(best_idx_reg);
                    it_reg    <= (it_reg == 6'd1 && !cmp_v_reg) ? '0 : it_reg + 1'b1;
                end
                ST_ROOT:  it_reg <= (it_reg == 6'(ROOT_W)) ? '0 : it_reg + 1'b1;
                ST_DIV:
                begin
                    if (it_reg == 6'(QUO_W))
                    begin
                        it_reg <= '0;
                        j_reg  <= j_reg + 1'b1;
                    end
                    else it_reg <= it_reg + 1'b1;
                end
                default: j_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [DIFF_W-1:0] dj;
        logic [PROD_W-1:0]        mag;
        logic [SUM_W-1:0]         trial;
        logic [QUO_W:0]           sh;
        logic signed [ANGLE_WIDTH+1:0] v, hi, lo;
        if (in_xfer)
        begin
            item_reg <= in_ch.data;
            drop_reg <= (in_ch.data.command == CMD_APPEND) &&
                        (total_reg == CNT_W'(TREE_DEPTH));
            root_reg <= '0;
            for (int j = 0; j < JOINT_COUNT; j++)
                res_reg[j] <= (ANGLE_WIDTH+2)'(in_ch.data.angle[j]);
        end
        if (state_reg == ST_SCAN && scan_win)
        begin
            best_s_reg   <= node_dist;
            best_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == ST_FETCH && it_reg == 6'd1 && !cmp_v_reg)
        begin
            near_reg <= rd_reg;
            rem_reg  <= best_s_reg;
        end
        if (state_reg == ST_ROOT && it_reg != '0)
        begin
            trial = SUM_W'({root_reg, 2'b01}) << (2 * (ROOT_W - int'(it_reg)));
            if (rem_reg >= trial && (trial >> (2 * (ROOT_W - int'(it_reg))))
                == SUM_W'({root_reg, 2'b01}))
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
        end
        if (state_reg == ST_DIV)
        begin
            if (it_reg == '0)
            begin
                dj  = DIFF_W'(item_reg.angle[j_reg]) - DIFF_W'(near_reg[j_reg]);
                mag = PROD_W'(step_reg) * PROD_W'(dj[DIFF_W-1] ? -dj : dj);
                dneg_reg <= dj[DIFF_W-1];
                dq_reg   <= mag;
                dr_reg   <= '0;
            end
            else
            begin
                sh = {dr_reg[QUO_W-1:0], dq_reg[QUO_W-1]};
                if (sh >= (QUO_W+1)'(root_reg))
                begin
                    dr_reg <= sh - (QUO_W+1)'(root_reg);
                    dq_reg <= {dq_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    dr_reg <= sh;
                    dq_reg <= {dq_reg[QUO_W-2:0], 1'b0};
                end
                if (it_reg == 6'(QUO_W))
                begin
                    v = (ANGLE_WIDTH+2)'(near_reg[j_reg]) +
                        (dneg_reg ? -(ANGLE_WIDTH+2)'({dq_reg[QUO_W-2:0],
                                     sh >= (QUO_W+1)'(root_reg)})
                                  : (ANGLE_WIDTH+2)'({dq_reg[QUO_W-2:0],
                                     sh >= (QUO_W+1)'(root_reg)}));
                    res_reg[j_reg] <= v;
                end
            end
        end
        if (state_reg == ST_OUT)
        begin
            out_reg.stored_nodes  <= total_reg;
            out_reg.dropped       <= drop_reg;
            out_reg.found         <= item_reg.command == CMD_QUERY && total_reg != '0;
            out_reg.nearest_index <= (item_reg.command == CMD_QUERY && total_reg != '0)
                                     ? best_idx_reg : '0;
            for (int j = 0; j < JOINT_COUNT; j++)
            begin
                hi = (ANGLE_WIDTH+2)'(signed'(lim_reg[j][31:16]));
                lo = (ANGLE_WIDTH+2)'(signed'(lim_reg[j][15:0]));
                v  = res_reg[j];
                if (v > hi) v = hi;
                if (v < lo) v = lo;
                out_reg.steered[j] <= (item_reg.command == CMD_QUERY && total_reg != '0)
                                      ? v[ANGLE_WIDTH-1:0] : '0;
            end
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(TREE_DEPTH))
        else $error("count overflow");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_v_reg)
        else $error("result lost");
endmodule

// File: tb/tb_tree_nearest_node_and_steer.sv
`timescale 1ns / 1ps
module tb_tree_nearest_node_and_steer;
    import tnns_pkg::*;

    typedef struct {
        cmd_t      cmd;
        node_t     angle;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    tnns_in_if  in_ch();
    tnns_out_if out_ch();

    tree_nearest_node_and_steer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    node_t        tree_nodes [TREE_DEPTH];
    int unsigned  node_count;
    int unsigned  step_len;
    logic [31:0]  joint_lim [JOINT_COUNT];
    out_item_t    pending_results [$];
    dir_row_t     dir_rows [$];
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 6000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_item_t steer_and_track(in_item_t it);
        out_item_t       res;
        longint          q [JOINT_COUNT];
        longint          dv [JOINT_COUNT];
        longint unsigned s;
        longint unsigned best_s;
        longint          root;
        longint          lo;
        longint          hi;
        int unsigned     best;
        res = '0;
        best = 0;
        best_s = 0;
        for (int j = 0; j < JOINT_COUNT; j++)
            q[j] = longint'(it.angle[j]);
        case (it.command)
            CMD_RESTART:
            begin
                tree_nodes[0] = it.angle;
                node_count = 1;
            end
            CMD_APPEND:
            begin
                if (node_count < TREE_DEPTH)
                begin
                    tree_nodes[node_count] = it.angle;
                    node_count++;
                end
                else
                    res.dropped = 1'b1;
            end
            CMD_QUERY:
            begin
                if (node_count > 0)
                begin
                    for (int unsigned i = 0; i < node_count; i++)
                    begin
                        s = 0;
                        for (int j = 0; j < JOINT_COUNT; j++)
                        begin
                            dv[j] = q[j] - longint'(tree_nodes[i][j]);
                            s += longint'(dv[j] * dv[j]);
                        end
                        if (i == 0 || s < best_s)
                        begin
                            best_s = s;
                            best = i;
                        end
                    end
                    if (best_s > longint'(step_len) * step_len)
                    begin
                        root = longint'(root_floor(best_s));
                        for (int j = 0; j < JOINT_COUNT; j++)
                        begin
                            dv[j] = q[j] - longint'(tree_nodes[best][j]);
                            q[j] = longint'(tree_nodes[best][j])
                                   + (longint'(step_len) * dv[j]) / root;
                        end
                    end
                    for (int j = 0; j < JOINT_COUNT; j++)
                    begin
                        lo = longint'($signed(joint_lim[j][15:0]));
                        hi = longint'($signed(joint_lim[j][31:16]));
                        if (q[j] > hi)
                            q[j] = hi;
                        if (q[j] < lo)
                            q[j] = lo;
                        res.steered[j] = q[j][15:0];
                    end
                    res.nearest_index = best[IDX_W-1:0];
                    res.found = 1'b1;
                end
            end
            default: ;
        endcase
        res.stored_nodes = node_count[CNT_W-1:0];
        return res;
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        out_item_t got;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        got = steer_and_track(it);
        pending_results = {pending_results, typed ? want : got};
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_STEP)
            step_len = value[14:0];
        else
            joint_lim[idx - CFG_J0] = value;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: %p", got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.nearest_index !== want.nearest_index)
                begin
                    $error("nearest_index exp %0d got %0d", want.nearest_index,
                           got.nearest_index);
                    fail_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, got.found);
                    fail_count++;
                end
                for (int j = 0; j < JOINT_COUNT; j++)
                    if (got.steered[j] !== want.steered[j])
                    begin
                        $error("steered_%0d exp %0d got %0d", j,
                               want.steered[j], got.steered[j]);
                        fail_count++;
                    end
                if (got.stored_nodes !== want.stored_nodes)
                begin
                    $error("stored_nodes exp %0d got %0d", want.stored_nodes,
                           got.stored_nodes);
                    fail_count++;
                end
                if (got.dropped !== want.dropped)
                begin
                    $error("dropped exp %0d got %0d", want.dropped, got.dropped);
                    fail_count++;
                end
            end
        end
    end

    function automatic angle_t jitter(angle_t base, int span);
        int v;
        v = int'(base) + $urandom_range(0, 2 * span) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return angle_t'(v);
    endfunction

    function automatic node_t random_node();
        node_t n;
        node_t base;
        int    span;
        if (node_count != 0 && $urandom_range(0, 99) < 70)
        begin
            base = tree_nodes[$urandom_range(0, node_count - 1)];
            span = ($urandom_range(0, 1) != 0) ? 300 : 4000;
            for (int j = 0; j < JOINT_COUNT; j++)
                n[j] = jitter(base[j], span);
        end
        else
            for (int j = 0; j < JOINT_COUNT; j++)
                n[j] = angle_t'($urandom_range(0, 65535));
        return n;
    endfunction

    function automatic void add_row(cmd_t c, node_t a, bit typed, int stored);
        dir_row_t r;
        r.cmd = c;
        r.angle = a;
        r.typed = typed;
        r.want = '0;
        r.want.stored_nodes = stored[CNT_W-1:0];
        dir_rows = {dir_rows, r};
    endfunction

    task automatic random_phase(int n_items);
        in_item_t it;
        int unsigned pick;
        it.command = CMD_RESTART;
        it.angle = random_node();
        send_item(it, 1'b0, '0);
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                it.command = CMD_RESTART;
            else if (pick < 8)
                it.command = CMD_NONE;
            else if (pick < 50)
                it.command = CMD_APPEND;
            else
                it.command = CMD_QUERY;
            it.angle = random_node();
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic random_config();
        write_reg(CFG_STEP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 3000));
        for (int j = 0; j < JOINT_COUNT; j++)
            write_reg(CFG_IDX_W'(CFG_J0 + j), $urandom());
    endtask

    initial
    begin
        node_t    lo_n;
        node_t    hi_n;
        node_t    zero_n;
        node_t    mix_n;
        in_item_t it;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        node_count = 0;
        step_len = 205;
        joint_lim = '{834063946, 609147826, 632478286, 834063946, 599710786,
                      1686608761};
        tx_idle_pct = 19;
        rx_idle_pct = 53;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            lo_n[j] = 16'sh8000;
            hi_n[j] = 16'sh7fff;
            zero_n[j] = '0;
            mix_n[j] = (j % 2 != 0) ? 16'sh7fff : 16'sh8000;
        end
        add_row(CMD_QUERY, hi_n, 1'b1, 0);
        add_row(CMD_APPEND, lo_n, 1'b1, 1);
        add_row(CMD_QUERY, zero_n, 1'b0, 1);
        add_row(CMD_RESTART, hi_n, 1'b1, 1);
        add_row(CMD_APPEND, lo_n, 1'b1, 2);
        add_row(CMD_APPEND, hi_n, 1'b1, 3);
        add_row(CMD_QUERY, hi_n, 1'b0, 3);
        add_row(CMD_QUERY, lo_n, 1'b0, 3);
        add_row(CMD_QUERY, mix_n, 1'b0, 3);
        add_row(CMD_QUERY, zero_n, 1'b0, 3);
        add_row(CMD_NONE, mix_n, 1'b1, 3);
        add_row(CMD_RESTART, zero_n, 1'b1, 1);
        add_row(CMD_QUERY, zero_n, 1'b0, 1);
        add_row(CMD_QUERY, node_t'({6{16'sd100}}), 1'b0, 1);
        add_row(CMD_QUERY, node_t'({6{16'sd20000}}), 1'b0, 1);
        add_row(CMD_APPEND, zero_n, 1'b1, 2);
        add_row(CMD_QUERY, node_t'({6{16'sd50}}), 1'b0, 2);
        add_row(CMD_QUERY, lo_n, 1'b0, 2);
        foreach (dir_rows[r])
        begin
            it.command = dir_rows[r].cmd;
            it.angle = dir_rows[r].angle;
            send_item(it, dir_rows[r].typed, dir_rows[r].want);
        end
        drain_results();

        // step extremes, single-value and inverted limit windows
        write_reg(CFG_STEP, 32'd0);
        write_reg(CFG_J0, 32'h7fff_8000);
        write_reg(CFG_IDX_W'(CFG_J0 + 1), 32'h8000_7fff);
        write_reg(CFG_IDX_W'(CFG_J0 + 2), 32'h0000_0000);
        write_reg(CFG_IDX_W'(CFG_J0 + 3), 32'hffff_ffff);
        write_reg(CFG_IDX_W'(CFG_J0 + 4), 32'h1000_f000);
        write_reg(CFG_IDX_W'(CFG_J0 + 5), 32'h7fff_8000);
        random_phase(40);
        drain_results();
        write_reg(CFG_STEP, 32'd32767);
        random_phase(30);
        drain_results();

        random_config();
        tx_idle_pct = 53;
        rx_idle_pct = 19;
        random_phase(70);
        drain_results();

        random_config();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(70);
        drain_results();

        // fill the store to capacity, then overflow it
        write_reg(CFG_STEP, 32'd205);
        for (int j = 0; j < JOINT_COUNT; j++)
            write_reg(CFG_IDX_W'(CFG_J0 + j), 32'h7fff_8000);
        it.command = CMD_RESTART;
        it.angle = random_node();
        send_item(it, 1'b0, '0);
        for (int k = 1; k < TREE_DEPTH + 3; k++)
        begin
            it.command = CMD_APPEND;
            it.angle = random_node();
            send_item(it, 1'b0, '0);
        end
        for (int k = 0; k < 3; k++)
        begin
            it.command = CMD_QUERY;
            it.angle = random_node();
            send_item(it, 1'b0, '0);
        end
        drain_results();
        repeat (50) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
